FILE: rtl/pvenc_pkg.sv
// Shared types and constants for the proof line varint encoder.
// No dependencies; the RTL modules and the bench refer to it by scoped names.
package pvenc_pkg;

  localparam int VAL_W = 64;
  localparam int GRP_W = 7;
  localparam int N_GRP = 10;
  localparam int XG_W  = GRP_W * N_GRP;
  localparam int CNT_W = 4;

  localparam logic [CNT_W-1:0] LAST_GRP = CNT_W'(N_GRP - 1);

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_IMPORT = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_NUMBER = 3'd3;
  localparam logic [2:0] ACT_TERM   = 3'd4;

  localparam logic [7:0] HDR_ADD    = 8'h61;
  localparam logic [7:0] HDR_IMPORT = 8'h69;
  localparam logic [7:0] HDR_DELETE = 8'h64;
  localparam logic [7:0] HDR_TERM   = 8'h00;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_HDR,
    E_NUM
  } emit_state_t;

  // converted item handed from the converter to the byte emitter
  typedef struct packed {
    logic [2:0]       action;
    logic [XG_W-1:0]  groups;   // 7-bit groups of the mapped number, group 0 lowest
    logic [CNT_W-1:0] nlast;    // index of the highest nonzero group (0 if none)
  } hand_t;

endpackage

FILE: rtl/pvenc_ifs.sv
// Valid/ready channel interfaces for the encoder input and byte output.
// Depends on nothing.
interface pvenc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [63:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface pvenc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

FILE: rtl/pvenc_conv.sv
// Digit-serial converter: maps v to 2*|v| + sign, one 7-bit group per cycle.
// Depends on pvenc_pkg and pvenc_in_if.
module pvenc_conv (
  input  logic              clk,
  input  logic              rst_n,
  pvenc_in_if.sink          in_s,
  output logic              hand_valid,
  input  logic              hand_ready,
  output pvenc_pkg::hand_t  hand
);

  pvenc_pkg::conv_state_t st_r, st_nxt;

  logic [pvenc_pkg::XG_W-1:0]  sreg_r, sreg_nxt;
  logic [pvenc_pkg::XG_W-1:0]  xg_r, xg_nxt;
  logic [pvenc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pvenc_pkg::CNT_W-1:0] nlast_r, nlast_nxt;
  logic [2:0]                  act_r, act_nxt;
  logic                        neg_r, neg_nxt;
  logic                        carry_r, carry_nxt;
  logic                        prev_r, prev_nxt;

  logic                        load;
  logic [pvenc_pkg::GRP_W-1:0] digit;
  logic [pvenc_pkg::GRP_W:0]   sum;
  logic [pvenc_pkg::GRP_W-1:0] grp;

  assign load = in_s.valid && in_s.ready;

  // magnitude digit: for negative inputs, ~r plus the running carry
  always_comb begin
    digit = neg_r ? ~sreg_r[pvenc_pkg::GRP_W-1:0] : sreg_r[pvenc_pkg::GRP_W-1:0];
    sum   = {1'b0, digit} + {{pvenc_pkg::GRP_W{1'b0}}, neg_r & carry_r};
    // x is the magnitude shifted up one with the sign in bit 0; the top group keeps one bit
    if (cnt_r == pvenc_pkg::LAST_GRP) begin
      grp = {{(pvenc_pkg::GRP_W-1){1'b0}}, prev_r};
    end else begin
      grp = {sum[pvenc_pkg::GRP_W-2:0], prev_r};
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pvenc_pkg::C_IDLE: begin
        if (load) st_nxt = pvenc_pkg::C_RUN;
      end
      pvenc_pkg::C_RUN: begin
        if (cnt_r == pvenc_pkg::LAST_GRP) st_nxt = pvenc_pkg::C_DONE;
      end
      pvenc_pkg::C_DONE: begin
        if (load) begin
          st_nxt = pvenc_pkg::C_RUN;
        end else if (hand_ready) begin
          st_nxt = pvenc_pkg::C_IDLE;
        end
      end
      default: st_nxt = pvenc_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    in_s.ready = 1'b0;
    hand_valid = 1'b0;
    unique case (st_r)
      pvenc_pkg::C_IDLE: in_s.ready = 1'b1;
      pvenc_pkg::C_RUN:  in_s.ready = 1'b0;
      pvenc_pkg::C_DONE: begin
        hand_valid = 1'b1;
        in_s.ready = hand_ready;
      end
      default: in_s.ready = 1'b0;
    endcase
  end

  always_comb begin
    sreg_nxt  = sreg_r;
    xg_nxt    = xg_r;
    cnt_nxt   = cnt_r;
    nlast_nxt = nlast_r;
    act_nxt   = act_r;
    neg_nxt   = neg_r;
    carry_nxt = carry_r;
    prev_nxt  = prev_r;
    if (load) begin
      sreg_nxt  = {{(pvenc_pkg::XG_W-pvenc_pkg::VAL_W){in_s.value[pvenc_pkg::VAL_W-1]}},
                   in_s.value};
      cnt_nxt   = '0;
      nlast_nxt = '0;
      act_nxt   = in_s.action;
      neg_nxt   = in_s.value[pvenc_pkg::VAL_W-1];
      carry_nxt = 1'b1;
      prev_nxt  = in_s.value[pvenc_pkg::VAL_W-1];
    end else if (st_r == pvenc_pkg::C_RUN) begin
      sreg_nxt  = {{pvenc_pkg::GRP_W{1'b0}}, sreg_r[pvenc_pkg::XG_W-1:pvenc_pkg::GRP_W]};
      xg_nxt    = {grp, xg_r[pvenc_pkg::XG_W-1:pvenc_pkg::GRP_W]};
      cnt_nxt   = cnt_r + 1'b1;
      carry_nxt = sum[pvenc_pkg::GRP_W];
      prev_nxt  = sum[pvenc_pkg::GRP_W-1];
      if (grp != '0) nlast_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pvenc_pkg::C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sreg_r  <= sreg_nxt;
    xg_r    <= xg_nxt;
    cnt_r   <= cnt_nxt;
    nlast_r <= nlast_nxt;
    act_r   <= act_nxt;
    neg_r   <= neg_nxt;
    carry_r <= carry_nxt;
    prev_r  <= prev_nxt;
  end

  assign hand = '{action: act_r, groups: xg_r, nlast: nlast_r};

endmodule

FILE: rtl/pvenc_emit.sv
// Byte emitter: a header byte, the converted groups with continuation bits, or both, by action.
// Depends on pvenc_pkg and pvenc_out_if.
module pvenc_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hand_valid,
  output logic              hand_ready,
  input  pvenc_pkg::hand_t  hand,
  pvenc_out_if.source       out_m
);

  pvenc_pkg::emit_state_t st_r, st_nxt, dec_st;

  logic [pvenc_pkg::XG_W-1:0]  xg_r, xg_nxt;
  logic [pvenc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pvenc_pkg::CNT_W-1:0] nlast_r, nlast_nxt;
  logic [7:0]                  hdr_r, hdr_nxt;
  logic                        hdr_last_r, hdr_last_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;

  logic adv, take, is_last, done_now;

  assign adv      = !out_valid_r || out_m.ready;
  assign is_last  = (cnt_r == nlast_r);
  assign done_now = adv && (((st_r == pvenc_pkg::E_HDR) && hdr_last_r) ||
                            ((st_r == pvenc_pkg::E_NUM) && is_last));
  assign take     = hand_valid && hand_ready;

  always_comb begin
    unique case (hand.action)
      pvenc_pkg::ACT_ADD,
      pvenc_pkg::ACT_IMPORT,
      pvenc_pkg::ACT_DELETE,
      pvenc_pkg::ACT_TERM:   dec_st = pvenc_pkg::E_HDR;
      pvenc_pkg::ACT_NUMBER: dec_st = pvenc_pkg::E_NUM;
      default:               dec_st = pvenc_pkg::E_IDLE;  // unused codes emit nothing
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      pvenc_pkg::E_IDLE: begin
        if (take) st_nxt = dec_st;
      end
      pvenc_pkg::E_HDR: begin
        if (adv) begin
          if (!hdr_last_r)  st_nxt = pvenc_pkg::E_NUM;
          else if (take)    st_nxt = dec_st;
          else              st_nxt = pvenc_pkg::E_IDLE;
        end
      end
      pvenc_pkg::E_NUM: begin
        if (adv && is_last) st_nxt = take ? dec_st : pvenc_pkg::E_IDLE;
      end
      default: st_nxt = pvenc_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    hand_ready = (st_r == pvenc_pkg::E_IDLE) || done_now;
  end

  always_comb begin
    xg_nxt        = xg_r;
    cnt_nxt       = cnt_r;
    nlast_nxt     = nlast_r;
    hdr_nxt       = hdr_r;
    hdr_last_nxt  = hdr_last_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (adv) begin
      unique case (st_r)
        pvenc_pkg::E_HDR: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hdr_r;
          out_last_nxt  = hdr_last_r;
        end
        pvenc_pkg::E_NUM: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = {!is_last, xg_r[pvenc_pkg::GRP_W-1:0]};
          out_last_nxt  = is_last;
          xg_nxt  = {{pvenc_pkg::GRP_W{1'b0}}, xg_r[pvenc_pkg::XG_W-1:pvenc_pkg::GRP_W]};
          cnt_nxt = cnt_r + 1'b1;
        end
        default: out_valid_nxt = 1'b0;
      endcase
    end

    if (take) begin
      xg_nxt       = hand.groups;
      nlast_nxt    = hand.nlast;
      cnt_nxt      = '0;
      hdr_last_nxt = (hand.action == pvenc_pkg::ACT_DELETE) ||
                     (hand.action == pvenc_pkg::ACT_TERM);
      unique case (hand.action)
        pvenc_pkg::ACT_ADD:    hdr_nxt = pvenc_pkg::HDR_ADD;
        pvenc_pkg::ACT_IMPORT: hdr_nxt = pvenc_pkg::HDR_IMPORT;
        pvenc_pkg::ACT_DELETE: hdr_nxt = pvenc_pkg::HDR_DELETE;
        default:               hdr_nxt = pvenc_pkg::HDR_TERM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= pvenc_pkg::E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xg_r       <= xg_nxt;
    cnt_r      <= cnt_nxt;
    nlast_r    <= nlast_nxt;
    hdr_r      <= hdr_nxt;
    hdr_last_r <= hdr_last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_m.valid     = out_valid_r;
  assign out_m.out_byte  = out_byte_r;
  assign out_m.last_byte = out_last_r;

endmodule

FILE: rtl/proof_line_varint_encoder_core.sv
// Proof record varint encoder, top level: converter feeding a byte emitter.
// The converter takes a new item only once its last one is handed to the emitter;
// the conversion is serial over 10 groups. Output runs at one byte per cycle while
// out_m.ready holds, up to 11 bytes per item.
// Reset (rst_n low, synchronous) clears both state machines and the output valid.
// Depends on pvenc_pkg, pvenc_ifs, pvenc_conv and pvenc_emit.
module proof_line_varint_encoder_core (
  input  logic          clk,
  input  logic          rst_n,
  pvenc_in_if.sink      in_s,
  pvenc_out_if.source   out_m
);

  logic             hand_valid;
  logic             hand_ready;
  pvenc_pkg::hand_t hand;

  pvenc_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand       (hand)
  );

  pvenc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand       (hand),
    .out_m      (out_m)
  );

  // a non-final byte is always followed at once by the next byte of the item
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && out_m.ready && !out_m.last_byte |=> out_m.valid)
    else $error("gap inside an item's byte burst");

  // a converted item waits unchanged until the emitter takes it
  a_hand_hold: assert property (@(posedge clk) disable iff (!rst_n)
    hand_valid && !hand_ready |=> hand_valid && $stable(hand))
    else $error("handoff item changed before transfer");

  // converter loads a new item only when its finished one is gone
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.valid && in_s.ready |-> !hand_valid || hand_ready)
    else $error("input taken while converted item pending");

endmodule

FILE: tb/sv/proof_line_varint_encoder_core_tb.sv
// Self-checking bench for proof_line_varint_encoder_core: directed table, then random
// records under changing idle patterns; bytes checked against typed rows or an encoder model.
// Depends on pvenc_pkg, the channel interfaces in pvenc_ifs and the core under test.
module proof_line_varint_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // action codes the block drops without output
  localparam logic [2:0] ACT_RSV5 = 3'd5;
  localparam logic [2:0] ACT_RSV6 = 3'd6;
  localparam logic [2:0] ACT_RSV7 = 3'd7;

  localparam logic [63:0] VAL_MAX  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] VAL_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_MIN1 = 64'h8000_0000_0000_0001;

  localparam int N_DIR      = 22;
  localparam int PER_PHASE  = 43;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_CYC  = 40;
  localparam int CYCLE_CAP  = 200000;
  localparam int SHOW_ERRS  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  // one record to send; typed rows carry their byte string, byte 0 lowest
  typedef struct packed {
    logic [2:0]  act;
    logic [63:0] val;
    logic        typed;
    logic [3:0]  n;
    logic [87:0] bytes;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pvenc_in_if  in_ch ();
  pvenc_out_if out_ch ();

  proof_line_varint_encoder_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch.sink),
    .out_m (out_ch.source)
  );

  enc_byte_t   expected_bytes [$];
  stim_row_t   offered_items [$];
  stim_row_t   dir_rows [0:N_DIR-1];
  int          errors;
  int          snd_idle;
  int          rcv_stall;
  bit          hold_req;
  int unsigned cycles;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= SHOW_ERRS) $display("%t: %s", $realtime, msg);
  endtask

  function automatic void expect_byte(input logic [7:0] b, input logic l);
    expected_bytes.insert(expected_bytes.size(), '{data: b, last: l});
  endfunction

  // sign-magnitude fold, then 7-bit groups LSB first with continuation bit
  task automatic encode_number(input logic [63:0] raw);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] x;
    neg = raw[63];
    mag = neg ? (~raw + 64'd1) : raw;
    x   = (mag << 1) + {63'd0, neg};
    while (x[63:7] != '0) begin
      expect_byte({1'b1, x[6:0]}, 1'b0);
      x = x >> 7;
    end
    expect_byte(x[7:0], 1'b1);
  endtask

  task automatic encode_item(input logic [2:0] act, input logic [63:0] val);
    case (act)
      pvenc_pkg::ACT_ADD: begin
        expect_byte(pvenc_pkg::HDR_ADD, 1'b0);
        encode_number(val);
      end
      pvenc_pkg::ACT_IMPORT: begin
        expect_byte(pvenc_pkg::HDR_IMPORT, 1'b0);
        encode_number(val);
      end
      pvenc_pkg::ACT_DELETE: expect_byte(pvenc_pkg::HDR_DELETE, 1'b1);
      pvenc_pkg::ACT_NUMBER: encode_number(val);
      pvenc_pkg::ACT_TERM:   expect_byte(pvenc_pkg::HDR_TERM, 1'b1);
      default: ;
    endcase
  endtask

  // input transfers: queue the bytes each accepted record should produce
  always @(posedge clk) begin : input_monitor
    stim_row_t r;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (offered_items.size() != 0) begin
        r = offered_items.pop_front();
      end else begin
        r = '{act: in_ch.action, val: in_ch.value, typed: 1'b0, n: 4'd0, bytes: '0};
      end
      if (r.typed) begin
        for (int i = 0; i < int'(r.n); i++)
          expect_byte(r.bytes[8*i +: 8], (i == int'(r.n) - 1));
      end else begin
        encode_item(r.act, r.val);
      end
    end
  end

  always @(posedge clk) begin : byte_check
    enc_byte_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %02h last=%0b", out_ch.out_byte,
                             out_ch.last_byte));
      end else begin
        e = expected_bytes.pop_front();
        if (out_ch.out_byte !== e.data || out_ch.last_byte !== e.last)
          note_error($sformatf("byte mismatch: expected %02h last=%0b, got %02h last=%0b",
                               e.data, e.last, out_ch.out_byte, out_ch.last_byte));
      end
    end
  end

  // output ready: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold     = HOLD_LEN;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_item(input stim_row_t r);
    while ($urandom_range(99) < snd_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= r.act;
    in_ch.value  <= r.val;
    offered_items.insert(offered_items.size(), r);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // magnitudes spread over all widths so every group count shows up
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          w;
    int          pick;
    pick = $urandom_range(19);
    v    = {$urandom, $urandom};
    w    = $urandom_range(64, 1);
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    if ($urandom_range(1)) v = ~v + 64'd1;
    case (pick)
      0: v = VAL_MAX;
      1: v = VAL_MIN;
      2: v = VAL_MIN1;
      3: v = '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    r = '0;
    if ($urandom_range(99) < 4) r.act = 3'($urandom_range(int'(ACT_RSV7), int'(ACT_RSV5)));
    else                        r.act = 3'($urandom_range(int'(pvenc_pkg::ACT_TERM)));
    r.val = rand_value();
    return r;
  endfunction

  initial begin : stimulus
    stim_row_t r;
    int        sent;
    errors       = 0;
    hold_req     = 1'b0;
    snd_idle     = 0;
    rcv_stall    = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = pvenc_pkg::ACT_ADD;
    in_ch.value  = '0;

    dir_rows = '{
      '{pvenc_pkg::ACT_NUMBER, 64'd0,  1'b1, 4'd1, 88'h00},
      '{pvenc_pkg::ACT_NUMBER, 64'd1,  1'b1, 4'd1, 88'h02},
      '{pvenc_pkg::ACT_NUMBER, 64'hffff_ffff_ffff_ffff, 1'b1, 4'd1, 88'h03},
      '{pvenc_pkg::ACT_NUMBER, 64'd63, 1'b1, 4'd1, 88'h7e},
      '{pvenc_pkg::ACT_NUMBER, 64'd64, 1'b1, 4'd2, 88'h0180},
      '{pvenc_pkg::ACT_NUMBER, 64'hffff_ffff_ffff_ffc0, 1'b1, 4'd2, 88'h0181},
      '{pvenc_pkg::ACT_NUMBER, VAL_MAX,  1'b1, 4'd10, 88'h01_ffff_ffff_ffff_ffff_fe},
      '{pvenc_pkg::ACT_NUMBER, VAL_MIN1, 1'b1, 4'd10, 88'h01_ffff_ffff_ffff_ffff_ff},
      // most negative value wraps to a single 0x01
      '{pvenc_pkg::ACT_NUMBER, VAL_MIN, 1'b1, 4'd1, 88'h01},
      '{pvenc_pkg::ACT_ADD,    64'd0,   1'b1, 4'd2, 88'h0061},
      '{pvenc_pkg::ACT_IMPORT, 64'd0,   1'b1, 4'd2, 88'h0069},
      '{pvenc_pkg::ACT_DELETE, 64'h1234_5678_9abc_def0, 1'b1, 4'd1, 88'h64},
      '{pvenc_pkg::ACT_TERM,   64'hffff_ffff_ffff_ffff, 1'b1, 4'd1, 88'h00},
      '{ACT_RSV5, 64'd5,   1'b1, 4'd0, 88'h0},
      '{ACT_RSV6, VAL_MAX, 1'b1, 4'd0, 88'h0},
      '{ACT_RSV7, VAL_MIN, 1'b1, 4'd0, 88'h0},
      '{pvenc_pkg::ACT_ADD,    VAL_MAX, 1'b0, 4'd0, 88'h0},
      '{pvenc_pkg::ACT_IMPORT, VAL_MIN, 1'b1, 4'd2, 88'h0169},
      '{pvenc_pkg::ACT_ADD,    64'hffff_ffff_ffff_ffff, 1'b0, 4'd0, 88'h0},
      '{pvenc_pkg::ACT_IMPORT, 64'h0123_4567_89ab_cdef, 1'b0, 4'd0, 88'h0},
      '{pvenc_pkg::ACT_NUMBER, 64'd8191, 1'b0, 4'd0, 88'h0},
      '{pvenc_pkg::ACT_DELETE, VAL_MIN,  1'b1, 4'd1, 88'h64}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 87; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 87; end
        default: begin snd_idle = 25; rcv_stall = 25; end
      endcase
      if (ph == 0) begin
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        // sender keeps offering while the output holds off
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PER_PHASE) begin
        r = rand_row();
        send_item(r);
        if (r.act <= pvenc_pkg::ACT_TERM) sent++;
      end
    end
    in_ch.valid <= 1'b0;
    // let the monitor queue the bytes of the last transfer first
    @(posedge clk);

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pvenc_pkg.sv
rtl/pvenc_ifs.sv
rtl/pvenc_conv.sv
rtl/pvenc_emit.sv
rtl/proof_line_varint_encoder_core.sv
tb/sv/proof_line_varint_encoder_core_tb.sv
